FILE: rtl/cpsp_pkg.sv
// Shared types, phase codes and token codes of the column page stream parser.
`default_nettype none
package cpsp_pkg;

  localparam int QDEPTH_DEF = 4;

  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_COLIDX   = 4'd0;
  localparam logic [PH_W-1:0] PH_ISSTR    = 4'd1;
  localparam logic [PH_W-1:0] PH_DICT     = 4'd2;
  localparam logic [PH_W-1:0] PH_RAWCNT   = 4'd3;
  localparam logic [PH_W-1:0] PH_PSIZE    = 4'd4;
  localparam logic [PH_W-1:0] PH_PAGECNT  = 4'd5;
  localparam logic [PH_W-1:0] PH_LOCAL    = 4'd6;
  localparam logic [PH_W-1:0] PH_WIDTH    = 4'd7;
  localparam logic [PH_W-1:0] PH_ROWS     = 4'd8;
  localparam logic [PH_W-1:0] PH_STRLEN   = 4'd9;
  localparam logic [PH_W-1:0] PH_STRBYTE  = 4'd10;
  localparam logic [PH_W-1:0] PH_DICTSIZE = 4'd11;
  localparam logic [PH_W-1:0] PH_OFFCNT   = 4'd12;
  localparam logic [PH_W-1:0] PH_OFFSET   = 4'd13;

  localparam logic [3:0] K_COLIDX   = 4'd0;
  localparam logic [3:0] K_ISSTR    = 4'd1;
  localparam logic [3:0] K_DICT     = 4'd2;
  localparam logic [3:0] K_RAWCNT   = 4'd3;
  localparam logic [3:0] K_PAGECNT  = 4'd4;
  localparam logic [3:0] K_LOCAL    = 4'd5;
  localparam logic [3:0] K_WIDTH    = 4'd6;
  localparam logic [3:0] K_ROWS     = 4'd7;
  localparam logic [3:0] K_STRLEN   = 4'd8;
  localparam logic [3:0] K_STRBYTE  = 4'd9;
  localparam logic [3:0] K_DICTSIZE = 4'd10;
  localparam logic [3:0] K_OFFCNT   = 4'd11;
  localparam logic [3:0] K_OFFSET   = 4'd12;
  localparam logic [3:0] K_TRUNC    = 4'd13;

  localparam logic [2:0] ROLE_RAW     = 3'd0;
  localparam logic [2:0] ROLE_PAGEMIN = 3'd1;
  localparam logic [2:0] ROLE_DIFFMAX = 3'd4;
  localparam logic [2:0] ROLE_DICTENT = 3'd5;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       is_zero;
    logic       is_one;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/column_page_stream_parser_core.sv
// Top level of the column page stream parser: front end, queue and back end.
`default_nettype none
// The parser takes a compressed column stream one byte per beat and emits one
// token beat for every field that a byte completes: column index, flags, counts,
// page header fields, string lengths, string bytes and page offsets. Words are
// four bytes, little-endian; the page-size word is consumed silently and offsets
// wider than four bytes keep their low four bytes. A byte flagged as the end of
// input that does not finish a column yields a token with truncated_error set
// (a kind 13 token if that byte completes no field) and the parser restarts.
// Throughput is one byte per clock cycle while the output is not stalled, set
// by the back end, which advances its parse state on every byte it pulls from
// the queue. An accepted byte is written into the queue, and when the back end
// pulls it, it parses the byte and loads the output register. The queue (QDEPTH
// beats) lets the input side keep streaming while the output is stalled; bytes
// that produce no token still pass through the back end at one per cycle unless
// a stalled token holds the output register.
module column_page_stream_parser_core #(
  parameter int QDEPTH = cpsp_pkg::QDEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_field_kind,
  output logic [2:0]       out_string_role,
  output logic [31:0]      out_field_value,
  output logic             out_column_end,
  output logic             out_truncated_error
);
  import cpsp_pkg::*;

  logic   push, q_full, q_valid, pop;
  entry_t push_entry, q_entry;

  // The front end tags each byte and stalls only when the queue is full.
  cpsp_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  cpsp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // The back end pulls a byte whenever its output register is free or drains.
  cpsp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_entry             (q_entry),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_field_kind      (out_field_kind),
    .out_string_role     (out_string_role),
    .out_field_value     (out_field_value),
    .out_column_end      (out_column_end),
    .out_truncated_error (out_truncated_error)
  );
endmodule
`default_nettype wire

FILE: rtl/cpsp_front.sv
// Front end: takes input beats, tags flag values and pushes them into the queue.
`default_nettype none
module cpsp_front (
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_end_of_input,
  input  wire logic            q_full,
  output logic                 push,
  output cpsp_pkg::entry_t     push_entry
);
  import cpsp_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry.data    = in_data_byte;
    push_entry.eoi     = in_end_of_input;
    push_entry.is_zero = (in_data_byte == 8'd0);
    push_entry.is_one  = (in_data_byte == 8'd1);
  end
endmodule
`default_nettype wire

FILE: rtl/cpsp_queue.sv
// Small queue that decouples the front end from the parser back end.
`default_nettype none
module cpsp_queue #(
  parameter int DEPTH = cpsp_pkg::QDEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cpsp_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output cpsp_pkg::entry_t      q_entry
);
  import cpsp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ptr_inc(wp_r) : wp_r;
    rp_nxt  = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cpsp_back.sv
// Back end: walks the column layout one byte a cycle and registers the tokens.
`default_nettype none
module cpsp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire cpsp_pkg::entry_t q_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [3:0]            out_field_kind,
  output logic [2:0]            out_string_role,
  output logic [31:0]           out_field_value,
  output logic                  out_column_end,
  output logic                  out_truncated_error
);
  import cpsp_pkg::*;

  typedef struct packed {
    logic            colend;
    logic [PH_W-1:0] phase;
    logic [2:0]      slot;
    logic [31:0]     items;
  } sdone_t;

  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [7:0]      pos_r, pos_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [31:0]     items_r, items_nxt;
  logic [31:0]     pages_r, pages_nxt;
  logic [31:0]     strrem_r, strrem_nxt;
  logic [2:0]      slot_r, slot_nxt;
  logic [7:0]      offw_r, offw_nxt;

  logic            ov_r, ov_nxt;
  logic [3:0]      kind_r, kind_nxt;
  logic [2:0]      role_r, role_nxt;
  logic [31:0]     val_r, val_nxt;
  logic            ce_r, ce_nxt;
  logic            te_r, te_nxt;

  logic [7:0]      b;
  logic [7:0]      pos_inc;
  logic [31:0]     wa;
  logic            wdone;
  logic [31:0]     pages_dec;
  logic [31:0]     items_dec;
  logic [31:0]     strrem_dec;
  logic            have, colend, trunc;
  sdone_t          sd;

  // Bookkeeping after a string ends: next string, next bound, or page part.
  function automatic sdone_t string_done(input logic [2:0] slot,
                                         input logic [31:0] items);
    sdone_t r;
    logic [31:0] idec;
    idec     = (items != '0) ? items - 32'd1 : '0;
    r.colend = 1'b0;
    r.phase  = PH_STRLEN;
    r.slot   = slot;
    r.items  = items;
    if (slot == ROLE_RAW) begin
      r.items  = idec;
      r.colend = (idec == '0);
    end else if (slot < ROLE_DIFFMAX) begin
      r.slot = slot + 3'd1;
    end else if (slot == ROLE_DIFFMAX) begin
      r.phase = PH_DICTSIZE;
    end else begin
      r.items = idec;
      r.phase = (idec == '0) ? PH_OFFCNT : PH_STRLEN;
    end
    return r;
  endfunction

  assign pop = q_valid && (!ov_r || !out_stall);
  assign b   = q_entry.data;

  always_comb begin
    pos_inc    = pos_r + 8'd1;
    wa         = acc_r | ({24'd0, b} << {pos_r[1:0], 3'b000});
    wdone      = (pos_inc >= 8'd4);
    pages_dec  = (pages_r != '0) ? pages_r - 32'd1 : '0;
    items_dec  = (items_r != '0) ? items_r - 32'd1 : '0;
    strrem_dec = (strrem_r != '0) ? strrem_r - 32'd1 : '0;
    sd         = string_done(slot_r, items_r);

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    items_nxt  = items_r;
    pages_nxt  = pages_r;
    strrem_nxt = strrem_r;
    slot_nxt   = slot_r;
    offw_nxt   = offw_r;
    have       = 1'b0;
    colend     = 1'b0;
    kind_nxt   = K_COLIDX;
    role_nxt   = ROLE_RAW;
    val_nxt    = '0;

    // Word phases share one little-endian assembler.
    if (phase_r == PH_COLIDX || phase_r == PH_RAWCNT || phase_r == PH_PSIZE ||
        phase_r == PH_PAGECNT || phase_r == PH_ROWS || phase_r == PH_STRLEN ||
        phase_r == PH_DICTSIZE || phase_r == PH_OFFCNT) begin
      if (wdone) begin
        acc_nxt = '0;
        pos_nxt = '0;
      end else begin
        acc_nxt = wa;
        pos_nxt = pos_inc;
      end
    end

    unique case (phase_r)
      PH_COLIDX: begin
        if (wdone) begin
          have = 1'b1; kind_nxt = K_COLIDX; val_nxt = wa; phase_nxt = PH_ISSTR;
        end
      end
      PH_ISSTR: begin
        have = 1'b1; kind_nxt = K_ISSTR; val_nxt = {31'd0, q_entry.is_one};
        phase_nxt = PH_DICT;
      end
      PH_DICT: begin
        have = 1'b1; kind_nxt = K_DICT; val_nxt = {31'd0, q_entry.is_one};
        phase_nxt = q_entry.is_one ? PH_PSIZE : PH_RAWCNT;
      end
      PH_RAWCNT: begin
        if (wdone) begin
          have = 1'b1; kind_nxt = K_RAWCNT; val_nxt = wa;
          items_nxt = wa; slot_nxt = ROLE_RAW;
          if (wa == '0) begin
            colend = 1'b1;
          end else begin
            phase_nxt = PH_STRLEN;
          end
        end
      end
      PH_PSIZE: begin
        if (wdone) begin
          phase_nxt = PH_PAGECNT;
        end
      end
      PH_PAGECNT: begin
        if (wdone) begin
          have = 1'b1; kind_nxt = K_PAGECNT; val_nxt = wa; pages_nxt = wa;
          if (wa == '0) begin
            colend = 1'b1;
          end else begin
            phase_nxt = PH_LOCAL;
          end
        end
      end
      PH_LOCAL: begin
        have = 1'b1; kind_nxt = K_LOCAL; val_nxt = {31'd0, q_entry.is_zero};
        phase_nxt = PH_WIDTH;
      end
      PH_WIDTH: begin
        have = 1'b1; kind_nxt = K_WIDTH; val_nxt = {24'd0, b}; offw_nxt = b;
        phase_nxt = PH_ROWS;
      end
      PH_ROWS: begin
        if (wdone) begin
          have = 1'b1; kind_nxt = K_ROWS; val_nxt = wa;
          slot_nxt = ROLE_PAGEMIN; phase_nxt = PH_STRLEN;
        end
      end
      PH_STRLEN: begin
        if (wdone) begin
          have = 1'b1; kind_nxt = K_STRLEN; role_nxt = slot_r; val_nxt = wa;
          strrem_nxt = wa;
          if (wa == '0) begin
            colend = sd.colend; phase_nxt = sd.phase;
            slot_nxt = sd.slot; items_nxt = sd.items;
          end else begin
            phase_nxt = PH_STRBYTE;
          end
        end
      end
      PH_STRBYTE: begin
        have = 1'b1; kind_nxt = K_STRBYTE; role_nxt = slot_r; val_nxt = {24'd0, b};
        strrem_nxt = strrem_dec;
        if (strrem_dec == '0) begin
          colend = sd.colend; phase_nxt = sd.phase;
          slot_nxt = sd.slot; items_nxt = sd.items;
        end
      end
      PH_DICTSIZE: begin
        if (wdone) begin
          have = 1'b1; kind_nxt = K_DICTSIZE; val_nxt = wa;
          items_nxt = wa; slot_nxt = ROLE_DICTENT;
          phase_nxt = (wa == '0) ? PH_OFFCNT : PH_STRLEN;
        end
      end
      PH_OFFCNT: begin
        if (wdone) begin
          have = 1'b1; kind_nxt = K_OFFCNT; val_nxt = wa; items_nxt = wa;
          if (wa == '0 || offw_r == '0) begin
            pages_nxt = pages_dec;
            if (pages_dec == '0) begin
              colend = 1'b1;
            end else begin
              phase_nxt = PH_LOCAL;
            end
          end else begin
            phase_nxt = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        // Bytes past the fourth are consumed but not kept.
        acc_nxt = (pos_r < 8'd4) ? wa : acc_r;
        pos_nxt = pos_inc;
        if (pos_inc >= offw_r) begin
          have = 1'b1; kind_nxt = K_OFFSET; val_nxt = acc_nxt;
          acc_nxt = '0; pos_nxt = '0; items_nxt = items_dec;
          if (items_dec == '0) begin
            pages_nxt = pages_dec;
            if (pages_dec == '0) begin
              colend = 1'b1;
            end else begin
              phase_nxt = PH_LOCAL;
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_COLIDX;
      end
    endcase

    trunc = q_entry.eoi && !colend;
    if (colend || trunc) begin
      phase_nxt  = PH_COLIDX;
      pos_nxt    = '0;
      acc_nxt    = '0;
      items_nxt  = '0;
      pages_nxt  = '0;
      strrem_nxt = '0;
      slot_nxt   = '0;
      offw_nxt   = '0;
    end
    if (trunc && !have) begin
      have = 1'b1; kind_nxt = K_TRUNC; role_nxt = ROLE_RAW; val_nxt = '0;
    end
    ce_nxt = colend;
    te_nxt = trunc;

    if (pop) begin
      ov_nxt = have;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_COLIDX;
      pos_r    <= '0;
      acc_r    <= '0;
      items_r  <= '0;
      pages_r  <= '0;
      strrem_r <= '0;
      slot_r   <= '0;
      offw_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        acc_r    <= acc_nxt;
        items_r  <= items_nxt;
        pages_r  <= pages_nxt;
        strrem_r <= strrem_nxt;
        slot_r   <= slot_nxt;
        offw_r   <= offw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= kind_nxt;
      role_r <= role_nxt;
      val_r  <= val_nxt;
      ce_r   <= ce_nxt;
      te_r   <= te_nxt;
    end
  end

  assign out_valid           = ov_r;
  assign out_field_kind      = kind_r;
  assign out_string_role     = role_r;
  assign out_field_value     = val_r;
  assign out_column_end      = ce_r;
  assign out_truncated_error = te_r;
endmodule
`default_nettype wire

FILE: rtl/cpsp_checker.sv
// Port-level checks for the column page stream parser, bound to the top level.
`default_nettype none
module cpsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  out_field_kind,
  input wire logic [2:0]  out_string_role,
  input wire logic [31:0] out_field_value,
  input wire logic        out_column_end,
  input wire logic        out_truncated_error
);
  import cpsp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_value) &&
      $stable(out_field_kind))
    else $error("stalled token changed");

  a_err_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_truncated_error && out_column_end))
    else $error("token both ends and truncates a column");

  a_trunc_tok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_kind == K_TRUNC |->
      out_truncated_error && out_field_value == '0 && out_string_role == ROLE_RAW)
    else $error("bad truncation token");

  a_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_role != ROLE_RAW |->
      out_field_kind == K_STRLEN || out_field_kind == K_STRBYTE)
    else $error("string role on a non-string token");
endmodule

bind column_page_stream_parser_core cpsp_checker u_cpsp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_field_kind      (out_field_kind),
  .out_string_role     (out_string_role),
  .out_field_value     (out_field_value),
  .out_column_end      (out_column_end),
  .out_truncated_error (out_truncated_error)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench of the column page stream parser core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cpsp_pkg::*;

  // Token beat as predicted or observed at the output channel.
  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  role;
    logic [31:0] value;
    logic        col_end;
    logic        trunc;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_field_kind;
  logic [2:0]  out_string_role;
  logic [31:0] out_field_value;
  logic        out_column_end;
  logic        out_truncated_error;

  column_page_stream_parser_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_end_of_input(in_end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_kind(out_field_kind), .out_string_role(out_string_role),
    .out_field_value(out_field_value), .out_column_end(out_column_end),
    .out_truncated_error(out_truncated_error)
  );

  // The clock runs with a 12 ns period.
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Parser state mirrored from the behavior of the block.
  logic [3:0]  pm_phase;
  logic [7:0]  pm_pos;
  logic [31:0] pm_acc;
  logic [31:0] pm_items;
  logic [31:0] pm_pages;
  logic [31:0] pm_strbytes;
  logic [2:0]  pm_slot;
  logic [7:0]  pm_width;

  token_t tokens_due[$];
  int     mismatch_count;
  int     token_count;
  int     bytes_sent;
  int     columns_sent;
  int     send_idle_pct;
  int     recv_stall_pct;
  logic [7:0] stream_buf[$];

  task automatic parser_clear();
    pm_phase = PH_COLIDX; pm_pos = 0; pm_acc = 0; pm_items = 0;
    pm_pages = 0; pm_strbytes = 0; pm_slot = 0; pm_width = 0;
  endtask

  // Collects a little-endian word; returns 1 when its fourth byte arrives.
  function automatic bit word_step(input logic [7:0] b, output logic [31:0] w);
    pm_acc = pm_acc | (32'(b) << (8 * pm_pos[1:0]));
    pm_pos = pm_pos + 8'd1;
    if (pm_pos >= 4) begin
      w = pm_acc; pm_acc = 0; pm_pos = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit page_finish();
    if (pm_pages > 0) pm_pages = pm_pages - 1;
    if (pm_pages == 0) return 1'b1;
    pm_phase = PH_LOCAL;
    return 1'b0;
  endfunction

  // Moves past a finished string: raw values, the four bounds, then entries.
  function automatic bit string_finish();
    if (pm_slot == ROLE_RAW) begin
      if (pm_items > 0) pm_items = pm_items - 1;
      if (pm_items == 0) return 1'b1;
      pm_phase = PH_STRLEN;
      return 1'b0;
    end
    if (pm_slot < ROLE_DIFFMAX) begin
      pm_slot = pm_slot + 3'd1; pm_phase = PH_STRLEN;
      return 1'b0;
    end
    if (pm_slot == ROLE_DIFFMAX) begin
      pm_phase = PH_DICTSIZE;
      return 1'b0;
    end
    if (pm_items > 0) pm_items = pm_items - 1;
    pm_phase = (pm_items == 0) ? PH_OFFCNT : PH_STRLEN;
    return 1'b0;
  endfunction

  // Predicts the token, if any, that one accepted byte produces.
  task automatic parse_byte(input logic [7:0] b, input logic eoi);
    bit have, colend, trunc;
    token_t t;
    logic [31:0] w;
    have = 0; colend = 0; t = '0;
    case (pm_phase)
      PH_COLIDX: if (word_step(b, w)) begin
        have = 1; t.kind = K_COLIDX; t.value = w; pm_phase = PH_ISSTR;
      end
      PH_ISSTR: begin
        have = 1; t.kind = K_ISSTR; t.value = (b == 1); pm_phase = PH_DICT;
      end
      PH_DICT: begin
        have = 1; t.kind = K_DICT; t.value = (b == 1);
        pm_phase = (b == 1) ? PH_PSIZE : PH_RAWCNT;
      end
      PH_RAWCNT: if (word_step(b, w)) begin
        have = 1; t.kind = K_RAWCNT; t.value = w; pm_items = w; pm_slot = ROLE_RAW;
        if (w == 0) colend = 1; else pm_phase = PH_STRLEN;
      end
      PH_PSIZE: if (word_step(b, w)) pm_phase = PH_PAGECNT;
      PH_PAGECNT: if (word_step(b, w)) begin
        have = 1; t.kind = K_PAGECNT; t.value = w; pm_pages = w;
        if (w == 0) colend = 1; else pm_phase = PH_LOCAL;
      end
      PH_LOCAL: begin
        have = 1; t.kind = K_LOCAL; t.value = (b == 0); pm_phase = PH_WIDTH;
      end
      PH_WIDTH: begin
        have = 1; t.kind = K_WIDTH; t.value = b; pm_width = b; pm_phase = PH_ROWS;
      end
      PH_ROWS: if (word_step(b, w)) begin
        have = 1; t.kind = K_ROWS; t.value = w; pm_slot = ROLE_PAGEMIN;
        pm_phase = PH_STRLEN;
      end
      PH_STRLEN: if (word_step(b, w)) begin
        have = 1; t.kind = K_STRLEN; t.role = pm_slot; t.value = w; pm_strbytes = w;
        if (w == 0) colend = string_finish(); else pm_phase = PH_STRBYTE;
      end
      PH_STRBYTE: begin
        have = 1; t.kind = K_STRBYTE; t.role = pm_slot; t.value = b;
        if (pm_strbytes > 0) pm_strbytes = pm_strbytes - 1;
        if (pm_strbytes == 0) colend = string_finish();
      end
      PH_DICTSIZE: if (word_step(b, w)) begin
        have = 1; t.kind = K_DICTSIZE; t.value = w; pm_items = w; pm_slot = ROLE_DICTENT;
        pm_phase = (w == 0) ? PH_OFFCNT : PH_STRLEN;
      end
      PH_OFFCNT: if (word_step(b, w)) begin
        have = 1; t.kind = K_OFFCNT; t.value = w; pm_items = w;
        if (w == 0 || pm_width == 0) colend = page_finish(); else pm_phase = PH_OFFSET;
      end
      default: begin
        // Offset bytes past the fourth are swallowed without touching the value.
        if (pm_pos < 4) pm_acc = pm_acc | (32'(b) << (8 * pm_pos[1:0]));
        pm_pos = pm_pos + 8'd1;
        if (pm_pos >= pm_width) begin
          have = 1; t.kind = K_OFFSET; t.value = pm_acc; pm_acc = 0; pm_pos = 0;
          if (pm_items > 0) pm_items = pm_items - 1;
          if (pm_items == 0) colend = page_finish();
        end
      end
    endcase
    trunc = eoi && !colend;
    if (colend || trunc) parser_clear();
    if (trunc && !have) begin
      have = 1; t = '0; t.kind = K_TRUNC;
    end
    if (have) begin
      t.col_end = colend; t.trunc = trunc;
      tokens_due.push_back(t);
    end
  endtask

  // Sends one byte beat, honoring the sender idle rate; updates the prediction
  // when the beat is accepted. Valid stays high afterwards so that the next
  // beat can follow without a gap; drain() drops it at the end.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_data_byte <= b; in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, eoi);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Compares each accepted token beat with the oldest prediction.
  always @(posedge clk) begin
    token_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_field_kind, out_string_role, out_field_value, out_column_end,
             out_truncated_error};
      token_count++;
      if (tokens_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected token: kind %0d role %0d value %h end %b trunc %b",
                   got.kind, got.role, got.value, got.col_end, got.trunc);
      end else begin
        want = tokens_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Token mismatch: expected kind %0d role %0d value %h end %b trunc %b, %s",
                     want.kind, want.role, want.value, want.col_end, want.trunc,
                     $sformatf("got kind %0d role %0d value %h end %b trunc %b",
                               got.kind, got.role, got.value, got.col_end, got.trunc));
        end
      end
    end
  end

  // Stream building helpers fill stream_buf, which is then sent in one go.
  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stream_buf.push_back(w[8*i +: 8]);
  endtask

  task automatic put_string(input int len);
    put_word(len);
    for (int i = 0; i < len; i++) stream_buf.push_back(8'($urandom));
  endtask

  // Random flag byte: half the time the opposite flag value, else the tested value or any value.
  function automatic logic [7:0] flag_byte(input logic [7:0] tested);
    int r;
    r = $urandom_range(3);
    if (r == 0) return 8'($urandom);
    return (r == 1) ? tested : ((tested == 0) ? 8'd1 : 8'd0);
  endfunction

  // Builds a well-formed random column; dict selects the paged layout.
  task automatic build_column(input bit dict);
    int pages, n, ow;
    put_word($urandom);
    stream_buf.push_back(flag_byte(8'd1));
    stream_buf.push_back(dict ? 8'd1 : (($urandom_range(1)) ? 8'd0 : 8'($urandom_range(255, 2))));
    if (!dict) begin
      n = $urandom_range(3);
      put_word(n);
      for (int i = 0; i < n; i++) put_string($urandom_range(3));
      return;
    end
    put_word($urandom);
    pages = $urandom_range(2);
    put_word(pages);
    for (int p = 0; p < pages; p++) begin
      stream_buf.push_back(flag_byte(8'd0));
      ow = $urandom_range(6);
      stream_buf.push_back(8'(ow));
      put_word($urandom);
      for (int s = 0; s < 4; s++) put_string($urandom_range(2));
      n = $urandom_range(2);
      put_word(n);
      for (int i = 0; i < n; i++) put_string($urandom_range(2));
      n = $urandom_range(3);
      put_word(n);
      for (int i = 0; i < n * ow; i++) stream_buf.push_back(8'($urandom));
    end
  endtask

  // Sends stream_buf; end of input may be flagged on its last byte.
  task automatic send_stream(input bit eoi_last);
    int n;
    n = stream_buf.size();
    for (int i = 0; i < n; i++) send_byte(stream_buf[i], eoi_last && (i == n - 1));
    stream_buf.delete();
    columns_sent++;
  endtask

  task automatic test_directed_extremes();
    // A raw column with zero values, ended exactly at column end.
    put_word(32'hFFFF_FFFF); stream_buf.push_back(8'hFF); stream_buf.push_back(8'h00);
    put_word(0);
    send_stream(1'b1);
    // Raw column with one two-byte string and extreme byte values.
    put_word(32'h0000_0000); stream_buf.push_back(8'h01); stream_buf.push_back(8'hFF);
    put_word(1); put_word(2); stream_buf.push_back(8'hFF); stream_buf.push_back(8'h00);
    send_stream(1'b0);
    // Dictionary column with zero pages.
    put_word(32'h8000_0001); stream_buf.push_back(8'h00); stream_buf.push_back(8'h01);
    put_word(32'hDEAD_BEEF); put_word(0);
    send_stream(1'b0);
  endtask

  task automatic test_page_layouts();
    // Pages with zero-width offsets, wide offsets and the local flag both ways.
    put_word(7); stream_buf.push_back(8'h01); stream_buf.push_back(8'h01);
    put_word(0); put_word(2);
    stream_buf.push_back(8'h00); stream_buf.push_back(8'h00); put_word(3);
    for (int s = 0; s < 4; s++) put_string(s & 1);
    put_word(0); put_word(2);
    stream_buf.push_back(8'h07); stream_buf.push_back(8'd6); put_word(1);
    for (int s = 0; s < 4; s++) put_string(0);
    put_word(1); put_string(1);
    put_word(1);
    for (int i = 0; i < 6; i++) stream_buf.push_back(8'hA0 + 8'(i));
    send_stream(1'b0);
  endtask

  task automatic test_truncation();
    // Ends mid word (kind 13) and ends on a field-completing byte.
    put_word(32'h1234_5678); stream_buf.push_back(8'h01);
    stream_buf.pop_back(); stream_buf.pop_back();
    send_stream(1'b1);
    put_word(9); stream_buf.push_back(8'h01);
    send_stream(1'b1);
  endtask

  // Random columns, mostly well formed; some are cut short or pure noise.
  task automatic test_random_columns(input int byte_goal);
    int r, cut;
    while (bytes_sent < byte_goal) begin
      r = $urandom_range(9);
      if (r == 0) begin
        for (int i = 0; i < $urandom_range(12, 1); i++) stream_buf.push_back(8'($urandom));
        send_stream($urandom_range(1));
      end else begin
        build_column(r > 4);
        if (r == 1) begin
          cut = $urandom_range(stream_buf.size() - 1, 1);
          while (stream_buf.size() > cut) stream_buf.pop_back();
          send_stream(1'b1);
        end else begin
          send_stream($urandom_range(3) == 0);
        end
      end
    end
  endtask

  // Drops valid and waits until every predicted token has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data_byte = '0; in_end_of_input = 1'b0;
    mismatch_count = 0; token_count = 0; bytes_sent = 0;
    columns_sent = 0; send_idle_pct = 0; recv_stall_pct = 0;
    parser_clear();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_page_layouts();
    test_truncation();
    // Idling phases: none, sender only, receiver only, then both.
    test_random_columns(bytes_sent + 100);
    send_idle_pct = 50;
    test_random_columns(bytes_sent + 100);
    send_idle_pct = 0; recv_stall_pct = 50;
    test_random_columns(bytes_sent + 100);
    send_idle_pct = 14; recv_stall_pct = 14;
    test_random_columns(bytes_sent + 100);
    drain();
    $display("Sent %0d bytes in %0d column streams, checked %0d tokens.",
             bytes_sent, columns_sent, token_count);
    $display("Covered raw and paged columns, wide and zero-width offsets, truncation.");
    if (mismatch_count == 0 && tokens_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
